FILE: rtl/qrs_pkg.sv
package qrs_pkg;

   localparam int W   = 32;         // word bits
   localparam int F   = 16;         // fraction bits
   localparam int DPW = 2 * W + 2;  // discriminant, padded to an even width
   localparam int SQW = W + 1;      // square root bits
   localparam int SRW = SQW + 2;    // square root remainder bits
   localparam int NSW = W + 3;      // signed numerator bits
   localparam int NMW = W + 2;      // numerator magnitude bits
   localparam int DMW = W + 1;      // denominator magnitude bits
   localparam int QW  = NMW + F;    // quotient bits
   localparam int RW  = DMW + 1;    // divider remainder bits

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_INF  = 2'd1,
      KIND_ONE  = 2'd2,
      KIND_TWO  = 2'd3
   } kind_type;

   typedef struct packed {
      logic signed [W-1:0] coef_quad;
      logic signed [W-1:0] coef_lin;
      logic signed [W-1:0] coef_const;
   } req_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic signed [W-1:0] root_first;
      logic signed [W-1:0] root_second;
      logic                overflow;
   } rsp_type;

   // travels alongside the square root
   typedef struct packed {
      kind_type            kind;
      logic                linear;
      logic signed [W-1:0] quad;
      logic signed [W-1:0] lin;
      logic signed [W-1:0] cnst;
   } side_type;

   // travels alongside the dividers
   typedef struct packed {
      kind_type kind;
      logic     neg_first;
      logic     neg_second;
   } dsb_type;

   function automatic logic [W-1:0] mag_w(input logic [W-1:0] x);
      mag_w = x[W-1] ? (~x + W'(1)) : x;
   endfunction

endpackage

FILE: rtl/qrs_disc.sv
module qrs_disc import qrs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  req_type        in_data,
   output logic           out_valid,
   output logic [DPW-1:0] out_d,
   output side_type       out_side
);

   logic                v0_ff;
   req_type             r0_ff;
   logic                v1_ff;
   logic [2*W-1:0]      b2_ff;
   logic [2*W-1:0]      ac_ff;
   req_type             r1_ff;
   logic                v2_ff;
   logic [DPW-1:0]      d_ff;
   side_type            side_ff;

   logic [W-1:0]        lin_mag;
   logic [W-1:0]        quad_mag;
   logic [W-1:0]        cnst_mag;
   logic [2*W-1:0]      b2_in;
   logic [2*W-1:0]      ac_in;
   logic [DPW-1:0]      b2x;
   logic [DPW-1:0]      acx;
   logic                opp;
   logic [DPW-1:0]      d_in;
   side_type            side_in;

   always_comb begin
      lin_mag  = mag_w(r0_ff.coef_lin);
      quad_mag = mag_w(r0_ff.coef_quad);
      cnst_mag = mag_w(r0_ff.coef_const);
      b2_in    = lin_mag * lin_mag;
      ac_in    = quad_mag * cnst_mag;
   end

   always_comb begin
      b2x = {2'b00, b2_ff};
      acx = {ac_ff, 2'b00};
      opp = (r1_ff.coef_const != '0) && (r1_ff.coef_quad[W-1] != r1_ff.coef_const[W-1]);
      d_in = '0;
      side_in.quad   = r1_ff.coef_quad;
      side_in.lin    = r1_ff.coef_lin;
      side_in.cnst   = r1_ff.coef_const;
      side_in.linear = (r1_ff.coef_quad == '0);
      side_in.kind   = KIND_NONE;
      if (r1_ff.coef_quad == '0) begin
         if (r1_ff.coef_lin != '0) side_in.kind = KIND_ONE;
         else if (r1_ff.coef_const == '0) side_in.kind = KIND_INF;
      end else if (opp) begin
         d_in = b2x + acx;
         side_in.kind = KIND_TWO;
      end else if (b2x > acx) begin
         d_in = b2x - acx;
         side_in.kind = KIND_TWO;
      end else if (b2x == acx) begin
         side_in.kind = KIND_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r0_ff   <= in_data;
         b2_ff   <= b2_in;
         ac_ff   <= ac_in;
         r1_ff   <= r0_ff;
         d_ff    <= d_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_d     = d_ff;
   assign out_side  = side_ff;

endmodule

FILE: rtl/qrs_sqrt.sv
module qrs_sqrt import qrs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  logic [DPW-1:0] in_d,
   input  side_type       in_side,
   output logic           out_valid,
   output logic [SQW-1:0] out_root,
   output side_type       out_side
);

   // one root bit per stage, two radicand bits shifted in each time
   logic           v_ff    [0:SQW];
   logic [SRW-1:0] rem_ff  [0:SQW];
   logic [SQW-1:0] root_ff [0:SQW];
   logic [DPW-1:0] dr_ff   [0:SQW];
   side_type       side_ff [0:SQW];

   always_comb begin
      v_ff[0]    = in_valid;
      rem_ff[0]  = '0;
      root_ff[0] = '0;
      dr_ff[0]   = in_d;
      side_ff[0] = in_side;
   end

   for (genvar i = 0; i < SQW; i++) begin : g_stage
      logic [SRW-1:0] rem_sh;
      logic [SRW-1:0] trial;
      logic [SRW-1:0] rem_in;
      logic [SQW-1:0] root_in;

      always_comb begin
         rem_sh = {rem_ff[i][SRW-3:0], dr_ff[i][DPW-1:DPW-2]};
         trial  = {root_ff[i], 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[i][SQW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[i][SQW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) v_ff[i+1] <= 1'b0;
         else if (en) v_ff[i+1] <= v_ff[i];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i+1]  <= rem_in;
            root_ff[i+1] <= root_in;
            dr_ff[i+1]   <= {dr_ff[i][DPW-3:0], 2'b00};
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   assign out_valid = v_ff[SQW];
   assign out_root  = root_ff[SQW];
   assign out_side  = side_ff[SQW];

endmodule

FILE: rtl/qrs_div.sv
module qrs_div import qrs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  logic [NMW-1:0] in_num_first,
   input  logic [NMW-1:0] in_num_second,
   input  logic [DMW-1:0] in_den,
   input  dsb_type        in_dsb,
   output logic           out_valid,
   output logic [QW-1:0]  out_q_first,
   output logic [QW-1:0]  out_q_second,
   output dsb_type        out_dsb
);

   // restoring division, one quotient bit per stage, both lanes share the divisor
   logic          v_ff   [0:QW];
   logic [RW-1:0] ra_ff  [0:QW];
   logic [RW-1:0] rb_ff  [0:QW];
   logic [QW-1:0] na_ff  [0:QW];
   logic [QW-1:0] nb_ff  [0:QW];
   logic [QW-1:0] qa_ff  [0:QW];
   logic [QW-1:0] qb_ff  [0:QW];
   logic [DMW-1:0] den_ff [0:QW];
   dsb_type       dsb_ff [0:QW];

   always_comb begin
      v_ff[0]   = in_valid;
      ra_ff[0]  = '0;
      rb_ff[0]  = '0;
      na_ff[0]  = {in_num_first, F'(0)};
      nb_ff[0]  = {in_num_second, F'(0)};
      qa_ff[0]  = '0;
      qb_ff[0]  = '0;
      den_ff[0] = in_den;
      dsb_ff[0] = in_dsb;
   end

   for (genvar i = 0; i < QW; i++) begin : g_stage
      logic [RW-1:0] sa;
      logic [RW-1:0] sb;
      logic [RW-1:0] dx;
      logic          ga;
      logic          gb;

      always_comb begin
         sa = {ra_ff[i][RW-2:0], na_ff[i][QW-1]};
         sb = {rb_ff[i][RW-2:0], nb_ff[i][QW-1]};
         dx = {1'b0, den_ff[i]};
         ga = (sa >= dx);
         gb = (sb >= dx);
      end

      always_ff @(posedge clock) begin
         if (reset) v_ff[i+1] <= 1'b0;
         else if (en) v_ff[i+1] <= v_ff[i];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ra_ff[i+1]  <= ga ? (sa - dx) : sa;
            rb_ff[i+1]  <= gb ? (sb - dx) : sb;
            qa_ff[i+1]  <= {qa_ff[i][QW-2:0], ga};
            qb_ff[i+1]  <= {qb_ff[i][QW-2:0], gb};
            na_ff[i+1]  <= {na_ff[i][QW-2:0], 1'b0};
            nb_ff[i+1]  <= {nb_ff[i][QW-2:0], 1'b0};
            den_ff[i+1] <= den_ff[i];
            dsb_ff[i+1] <= dsb_ff[i];
         end
      end
   end

   assign out_valid    = v_ff[QW];
   assign out_q_first  = qa_ff[QW];
   assign out_q_second = qb_ff[QW];
   assign out_dsb      = dsb_ff[QW];

endmodule

FILE: rtl/quadratic_root_solver.sv
// Pipeline: discriminant, one-bit-per-stage square root, numerator register,
// one-bit-per-stage dividers and output register; roots are Q16.16.
// Throughput: one word per cycle; a stalled result holds the whole pipeline.
// Reset: synchronous, clears the valid bits of every stage; no state is kept
// between words.
module quadratic_root_solver import qrs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic           en;
   logic           dv;
   logic [DPW-1:0] dd;
   side_type       dside;
   logic           sv;
   logic [SQW-1:0] sroot;
   side_type       sside;

   logic           nv_ff;
   logic [NMW-1:0] n1_ff;
   logic [NMW-1:0] n2_ff;
   logic [DMW-1:0] den_ff;
   dsb_type        ndsb_ff;

   logic           qv;
   logic [QW-1:0]  q1;
   logic [QW-1:0]  q2;
   dsb_type        qdsb;

   logic           rsp_valid_ff;
   rsp_type        rsp_ff;

   logic signed [NSW-1:0] lx;
   logic signed [NSW-1:0] sx;
   logic signed [NSW-1:0] n1s;
   logic signed [NSW-1:0] n2s;
   logic signed [NSW-1:0] dens;
   logic [NSW-1:0]        n1m;
   logic [NSW-1:0]        n2m;
   logic [NSW-1:0]        denm;
   dsb_type               dsb_in;

   logic [QW-1:0]  lim1;
   logic [QW-1:0]  lim2;
   logic           sat1;
   logic           sat2;
   logic [W-1:0]   v1;
   logic [W-1:0]   v2;
   logic [W-1:0]   r1;
   logic [W-1:0]   r2;
   rsp_type        rsp_in;

   // hold everything while a finished word waits
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   qrs_disc u_disc (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (dv),
      .out_d     (dd),
      .out_side  (dside)
   );

   qrs_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (dv),
      .in_d      (dd),
      .in_side   (dside),
      .out_valid (sv),
      .out_root  (sroot),
      .out_side  (sside)
   );

   // form numerators and the common divisor
   always_comb begin
      lx = NSW'(sside.lin);
      sx = NSW'($signed({1'b0, sroot}));
      if (sside.linear) begin
         n1s  = -NSW'(sside.cnst);
         n2s  = '0;
         dens = lx;
      end else begin
         n1s  = -lx + sx;
         n2s  = -lx - sx;
         dens = NSW'($signed({sside.quad, 1'b0}));
      end
      n1m  = n1s[NSW-1] ? NSW'(-n1s) : n1s;
      n2m  = n2s[NSW-1] ? NSW'(-n2s) : n2s;
      denm = dens[NSW-1] ? NSW'(-dens) : dens;
      dsb_in.kind       = sside.kind;
      dsb_in.neg_first  = n1s[NSW-1] ^ dens[NSW-1];
      dsb_in.neg_second = n2s[NSW-1] ^ dens[NSW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) nv_ff <= 1'b0;
      else if (en) nv_ff <= sv;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n1_ff   <= n1m[NMW-1:0];
         n2_ff   <= n2m[NMW-1:0];
         den_ff  <= denm[DMW-1:0];
         ndsb_ff <= dsb_in;
      end
   end

   qrs_div u_div (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .in_valid      (nv_ff),
      .in_num_first  (n1_ff),
      .in_num_second (n2_ff),
      .in_den        (den_ff),
      .in_dsb        (ndsb_ff),
      .out_valid     (qv),
      .out_q_first   (q1),
      .out_q_second  (q2),
      .out_dsb       (qdsb)
   );

   // saturate, apply sign, drop unused roots
   always_comb begin
      lim1 = qdsb.neg_first  ? (QW'(1) << (W - 1)) : ((QW'(1) << (W - 1)) - QW'(1));
      lim2 = qdsb.neg_second ? (QW'(1) << (W - 1)) : ((QW'(1) << (W - 1)) - QW'(1));
      sat1 = (q1 > lim1);
      sat2 = (q2 > lim2);
      v1   = sat1 ? lim1[W-1:0] : q1[W-1:0];
      v2   = sat2 ? lim2[W-1:0] : q2[W-1:0];
      r1   = qdsb.neg_first  ? (~v1 + W'(1)) : v1;
      r2   = qdsb.neg_second ? (~v2 + W'(1)) : v2;
      rsp_in.kind        = qdsb.kind;
      rsp_in.root_first  = '0;
      rsp_in.root_second = '0;
      rsp_in.overflow    = 1'b0;
      case (qdsb.kind)
         KIND_ONE: begin
            rsp_in.root_first = r1;
            rsp_in.overflow   = sat1;
         end
         KIND_TWO: begin
            rsp_in.root_first  = r1;
            rsp_in.root_second = r2;
            rsp_in.overflow    = sat1 | sat2;
         end
         default: begin
            rsp_in.overflow = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (en) rsp_valid_ff <= qv;
   end

   always_ff @(posedge clock) begin
      if (en) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
